// File: rtl/core/rangefinder_frame_crc_checker_core_assert.svh
// Assertion macros for the rangefinder frame CRC checker.
`ifndef RANGEFINDER_FRAME_CRC_CHECKER_CORE_ASSERT_SVH
`define RANGEFINDER_FRAME_CRC_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define RFCC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define RFCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define RFCC_ASSERT_SAME(label, clk, rst, ante, cons)
`define RFCC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/rfcc_pkg.sv
// Shared types and constants for the rangefinder frame CRC checker.
`timescale 1ns / 1ps
`default_nettype none

package rfcc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [3:0] POS_HUNT      = 4'd0;
  localparam logic [3:0] POS_FIRST     = 4'd1;
  localparam logic [3:0] CRC_FIRST_POS = 4'd2;
  localparam logic [3:0] CRC_HIGH_POS  = 4'd13;
  localparam logic [3:0] CRC_LOW_POS   = 4'd14;
  localparam logic [3:0] POS_MAX       = 4'd15;

  typedef enum logic [1:0] {
    CFG_START_BYTE    = 2'd0,
    CFG_DIST_HIGH_IDX = 2'd1,
    CFG_DIST_LOW_IDX  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [3:0] distance_high_index;
    logic [3:0] distance_low_index;
  } cfg_t;

  typedef struct packed {
    logic [3:0] pos;
    logic       result_load;
  } trk_status_t;

endpackage

`default_nettype wire

// File: rtl/core/rangefinder_frame_crc_checker_core.sv
// Top level of the rangefinder frame CRC checker.
// Latency: 2 register stages; the last byte passes the input register, then its result loads into the output register.
// Throughput: 1 byte per cycle while out_stall does not hold a result; one result per 15-byte frame.
// The input register takes a new byte while a result waits in the output register, if it is empty.
// Reset (rst, synchronous): hunting for the start byte, CRC 0xFFFF, config zero.
`timescale 1ns / 1ps
`default_nettype none
`include "rangefinder_frame_crc_checker_core_assert.svh"

module rangefinder_frame_crc_checker_core
  import rfcc_pkg::*;
#(
  parameter int PAYLOAD_LENGTH = 11
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] range_mm,
  output logic             crc_ok
);

  cfg_t        cfg;
  logic        in_reg_valid;
  logic [7:0]  in_reg_byte;
  logic        advance;
  logic        proc_valid;
  logic        in_accept;
  trk_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_START_BYTE:    cfg.sync_byte           <= cfg_data;
        CFG_DIST_HIGH_IDX: cfg.distance_high_index <= cfg_data[3:0];
        CFG_DIST_LOW_IDX:  cfg.distance_low_index  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_stall   = in_reg_valid && !advance;
  assign in_accept  = in_valid && !in_stall;
  assign proc_valid = in_reg_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_accept) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg_byte <= rx_byte;
    end
  end

  rfcc_frame_tracker #(
    .PAYLOAD_LENGTH (PAYLOAD_LENGTH)
  ) u_frame_tracker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .proc_valid  (proc_valid),
    .proc_byte   (in_reg_byte),
    .advance     (advance),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .range_mm    (range_mm),
    .crc_ok      (crc_ok)
  );

  `RFCC_ASSERT_SAME(a_stall_only_on_blocked_result, clk, rst, in_stall, out_valid && out_stall)
  `RFCC_ASSERT_NEXT(a_frame_end, clk, rst, status.result_load, out_valid && status.pos == POS_HUNT)
  `RFCC_ASSERT_SAME(a_pos_in_range, clk, rst, 1'b1, status.pos != POS_MAX)

endmodule

`default_nettype wire

// File: rtl/core/rfcc_crc_step.sv
// One-byte CRC-16/CCITT-FALSE update, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module rfcc_crc_step
  import rfcc_pkg::*;
(
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// File: rtl/core/rfcc_frame_tracker.sv
// Frame position tracking, CRC accumulation and result register.
`timescale 1ns / 1ps
`default_nettype none

module rfcc_frame_tracker
  import rfcc_pkg::*;
#(
  parameter int PAYLOAD_LENGTH = 11
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        proc_valid,
  input  wire logic [7:0]  proc_byte,
  output logic             advance,
  output trk_status_t      status,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] range_mm,
  output logic             crc_ok
);

  localparam logic [3:0] CRC_END = 4'(2 + PAYLOAD_LENGTH);

  logic [3:0]  pos;
  logic [15:0] running_crc;
  logic [7:0]  distance_high;
  logic [7:0]  distance_low;
  logic [7:0]  received_crc_high;

  logic [15:0] crc_upd;
  logic [7:0]  dist_high_next;
  logic [7:0]  dist_low_next;
  logic        in_window;
  logic        result_load;

  rfcc_crc_step u_crc_step (
    .crc_in  (running_crc),
    .data    (proc_byte),
    .crc_out (crc_upd)
  );

  assign advance     = !out_valid || !out_stall;
  assign in_window   = (pos >= CRC_FIRST_POS) && (pos < CRC_END);
  assign result_load = proc_valid && (pos >= CRC_LOW_POS);

  assign dist_high_next = (cfg.distance_high_index == pos) ? proc_byte : distance_high;
  assign dist_low_next  = (cfg.distance_low_index == pos) ? proc_byte : distance_low;

  assign status.pos         = pos;
  assign status.result_load = result_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos               <= POS_HUNT;
      running_crc       <= CRC_INIT;
      distance_high     <= '0;
      distance_low      <= '0;
      received_crc_high <= '0;
    end else if (proc_valid) begin
      if (pos == POS_HUNT) begin
        if (proc_byte == cfg.sync_byte) begin
          running_crc       <= CRC_INIT;
          distance_high     <= (cfg.distance_high_index == POS_HUNT) ? proc_byte : 8'h00;
          distance_low      <= (cfg.distance_low_index == POS_HUNT) ? proc_byte : 8'h00;
          received_crc_high <= '0;
          pos               <= POS_FIRST;
        end
      end else begin
        distance_high <= dist_high_next;
        distance_low  <= dist_low_next;
        if (in_window) begin
          running_crc <= crc_upd;
        end
        if (pos == CRC_HIGH_POS) begin
          received_crc_high <= proc_byte;
        end
        if (pos >= CRC_LOW_POS) begin
          pos <= POS_HUNT;
        end else begin
          pos <= pos + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      range_mm <= {dist_high_next, dist_low_next};
      crc_ok   <= (running_crc == {received_crc_high, proc_byte});
    end
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the rangefinder frame CRC checker core.
`timescale 1ns / 1ps

module testbench;
  import rfcc_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 300;

  typedef enum int {STIM_BYTE, STIM_CFG, STIM_MODE, STIM_HOLD, STIM_DRAIN} stim_kind_t;

  typedef struct {
    stim_kind_t  kind;
    cfg_index_t  reg_sel;
    int unsigned value;
    int unsigned value2;
  } stim_t;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        crc_ok;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] range_mm;
  logic        crc_ok;

  rangefinder_frame_crc_checker_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .range_mm(range_mm), .crc_ok(crc_ok)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stim_t         pending[$];
  frame_result_t expected_frames[$];
  int            errors = 0;
  int            quiet_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_request = 0;
  int            settle_count = 0;
  bit            byte_taken = 1'b0;

  // Frame tracker state
  cfg_t        trk_cfg = '0;
  logic [3:0]  trk_pos = POS_HUNT;
  logic [15:0] trk_crc = CRC_INIT;
  logic [7:0]  trk_dist_hi = '0;
  logic [7:0]  trk_dist_lo = '0;
  logic [7:0]  trk_crc_hi = '0;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic void latch_distance(input logic [3:0] pos, input logic [7:0] b);
    if (pos == trk_cfg.distance_high_index) trk_dist_hi = b;
    if (pos == trk_cfg.distance_low_index) trk_dist_lo = b;
  endfunction

  function automatic void track_byte(input logic [7:0] b);
    frame_result_t r;
    if (trk_pos == POS_HUNT) begin
      if (b == trk_cfg.sync_byte) begin
        trk_crc = CRC_INIT;
        trk_dist_hi = '0;
        trk_dist_lo = '0;
        trk_crc_hi = '0;
        latch_distance(POS_HUNT, b);
        trk_pos = POS_FIRST;
      end
    end else begin
      latch_distance(trk_pos, b);
      if (trk_pos >= CRC_FIRST_POS && trk_pos < CRC_HIGH_POS) trk_crc = crc16_byte(trk_crc, b);
      if (trk_pos == CRC_HIGH_POS) trk_crc_hi = b;
      if (trk_pos >= CRC_LOW_POS) begin
        r.range_mm = {trk_dist_hi, trk_dist_lo};
        r.crc_ok = (trk_crc == {trk_crc_hi, b});
        expected_frames.push_back(r);
        trk_pos = POS_HUNT;
      end else begin
        trk_pos = trk_pos + 4'd1;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Monitor: predicts on every input transaction, checks every result transaction
  always @(posedge clk) begin : monitor
    frame_result_t want;
    bit out_taken;
    if (rst) begin
      trk_cfg = '0;
      trk_pos = POS_HUNT;
      trk_crc = CRC_INIT;
      trk_dist_hi = '0;
      trk_dist_lo = '0;
      trk_crc_hi = '0;
      byte_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      byte_taken = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      if (out_taken) begin
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("unexpected result distance=%0d crc_ok=%0b",
                                    range_mm, crc_ok));
        end else begin
          want = expected_frames.pop_front();
          if (range_mm !== want.range_mm)
            report_mismatch($sformatf("range_mm got %0d want %0d",
                                      range_mm, want.range_mm));
          if (crc_ok !== want.crc_ok)
            report_mismatch($sformatf("crc_ok got %0b want %0b", crc_ok, want.crc_ok));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_START_BYTE:    trk_cfg.sync_byte = cfg_data;
          CFG_DIST_HIGH_IDX: trk_cfg.distance_high_index = cfg_data[3:0];
          CFG_DIST_LOW_IDX:  trk_cfg.distance_low_index = cfg_data[3:0];
          default: ;
        endcase
      end
      if (byte_taken) track_byte(rx_byte);
      quiet_cycles = (byte_taken || out_taken) ? 0 : quiet_cycles + 1;
    end
  end

  // Driver
  always @(negedge clk) begin : driver
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    logic       nxt_wr;
    logic [1:0] nxt_idx;
    logic [7:0] nxt_data;
    nxt_valid = in_valid;
    nxt_byte = rx_byte;
    nxt_wr = 1'b0;
    nxt_idx = cfg_index;
    nxt_data = cfg_data;
    if (!rst && !(in_valid && !byte_taken)) begin
      nxt_valid = 1'b0;
      if (pending.size() != 0) begin
        case (pending[0].kind)
          STIM_BYTE: begin
            if ($urandom_range(0, 99) >= send_idle_pct) begin
              nxt_valid = 1'b1;
              nxt_byte = pending[0].value[7:0];
              void'(pending.pop_front());
            end
          end
          STIM_CFG: begin
            nxt_wr = 1'b1;
            nxt_idx = pending[0].reg_sel;
            nxt_data = pending[0].value[7:0];
            void'(pending.pop_front());
          end
          STIM_MODE: begin
            send_idle_pct = pending[0].value;
            recv_stall_pct = pending[0].value2;
            void'(pending.pop_front());
          end
          STIM_HOLD: begin
            hold_request = pending[0].value;
            void'(pending.pop_front());
          end
          STIM_DRAIN: begin
            settle_count = (expected_frames.size() == 0) ? settle_count + 1 : 0;
            if (settle_count >= SETTLE_CYCLES) begin
              settle_count = 0;
              void'(pending.pop_front());
            end
          end
          default: void'(pending.pop_front());
        endcase
      end
    end
    in_valid <= nxt_valid;
    rx_byte <= nxt_byte;
    cfg_write <= nxt_wr;
    cfg_index <= nxt_idx;
    cfg_data <= nxt_data;
  end

  // Receiver back-pressure
  always @(negedge clk) begin : receiver
    int hold_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending.push_back('{STIM_BYTE, CFG_START_BYTE, b, 0});
  endtask

  task automatic push_cfg(input cfg_index_t sel, input logic [7:0] v);
    pending.push_back('{STIM_CFG, sel, v, 0});
  endtask

  task automatic push_mode(input int send_pct, input int recv_pct);
    pending.push_back('{STIM_MODE, CFG_START_BYTE, send_pct, recv_pct});
  endtask

  task automatic push_hold(input int cycles);
    pending.push_back('{STIM_HOLD, CFG_START_BYTE, cycles, 0});
  endtask

  // Waits for every result, then rewrites all three registers
  task automatic push_settings(input logic [7:0] sb, input logic [3:0] hi, input logic [3:0] lo);
    pending.push_back('{STIM_DRAIN, CFG_START_BYTE, 0, 0});
    push_cfg(CFG_START_BYTE, sb);
    push_cfg(CFG_DIST_HIGH_IDX, {4'd0, hi});
    push_cfg(CFG_DIST_LOW_IDX, {4'd0, lo});
  endtask

  // fill < 0 gives random body bytes; cut < 15 truncates the frame
  task automatic push_frame(input logic [7:0] sb, input int fill, input bit bad_crc,
                            input int cut);
    logic [7:0]  fr[15];
    logic [15:0] c;
    fr[0] = sb;
    for (int i = 1; i < 13; i++) fr[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    c = CRC_INIT;
    for (int i = CRC_FIRST_POS; i < CRC_HIGH_POS; i++) c = crc16_byte(c, fr[i]);
    fr[13] = c[15:8];
    fr[14] = c[7:0];
    if (bad_crc) fr[$urandom_range(13, 14)] ^= 8'(1 << $urandom_range(0, 7));
    for (int i = 0; i < cut; i++) push_byte(fr[i]);
  endtask

  initial begin : stimulus
    logic [7:0] sb;
    logic [3:0] hi, lo;
    int roll, frame_no;

    // Directed: reset settings, frame with all-zero start and body bytes
    push_mode(0, 0);
    push_frame(8'h00, 8'h00, 1'b0, 15);
    // Index fifteen, index zero, bad CRC
    push_settings(8'hFF, 4'd15, 4'd0);
    push_frame(8'hFF, 8'hFF, 1'b1, 15);
    // Start byte repeated inside the frame, distance taken from the CRC bytes
    push_settings(8'hA5, 4'd13, 4'd14);
    push_frame(8'hA5, 8'hA5, 1'b0, 15);

    frame_no = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin sb = 8'h5A; hi = 4'd3;  lo = 4'd4;  end
        1: begin sb = 8'h00; hi = 4'd14; lo = 4'd2;  end
        2: begin sb = 8'hFF; hi = 4'd12; lo = 4'd1;  end
        3: begin sb = 8'($urandom); hi = 4'd0; lo = 4'd15; end
        default: begin
          sb = 8'($urandom);
          hi = 4'($urandom_range(0, 15));
          lo = 4'($urandom_range(0, 15));
        end
      endcase
      push_settings(sb, hi, lo);
      for (int f = 0; f < 6; f++) begin
        case ((frame_no / 2) % 4)
          0: push_mode(0, 0);
          1: push_mode(46, 0);
          2: push_mode(0, 46);
          default: push_mode(14, 14);
        endcase
        frame_no++;
        if (ph == 2 && f == 1) begin
          push_mode(0, 0);
          push_hold(LONG_HOLD);
        end
        repeat ($urandom_range(0, 3)) push_byte(($urandom_range(0, 9) == 0) ? sb : 8'($urandom));
        roll = $urandom_range(0, 9);
        if (roll == 0) push_frame(sb, -1, 1'b0, $urandom_range(1, 14));
        else push_frame(sb, -1, (roll <= 2), 15);
      end
    end

    wait (rst == 1'b0);
    do @(posedge clk);
    while (pending.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (8) @(posedge clk);
    #1;
    if (expected_frames.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_frames.size()));
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : reset_seq
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
